// ===== hdl/hciatt_pkg.sv =====
// Package: shared job type and protocol constants for the ACL/ATT responder.
`default_nettype none
package hciatt_pkg;

   localparam logic [7:0] HCI_TYPE_ACL = 8'h02;
   localparam logic [7:0] HCI_TYPE_EVT = 8'h04;
   localparam logic [7:0] ATT_OP_FIND = 8'h10;
   localparam logic [7:0] ATT_OP_NOTIFY = 8'h1b;
   localparam logic [7:0] ATT_OP_ERROR = 8'h01;
   localparam logic [15:0] L2CAP_ATT_CID = 16'h0004;
   localparam logic [15:0] L2CAP_NTF_LEN = 16'h0004;
   localparam logic [15:0] NTF_ATTR_HANDLE = 16'h001b;
   localparam logic [3:0] HDR_BYTES = 4'd8;
   localparam logic [3:0] ERR_LAST_IDX = 4'd13;

   typedef struct packed {
      logic        notify;
      logic [11:0] handle;
      logic [7:0]  b0;
      logic [7:0]  b1;
   } job_type;

endpackage
`default_nettype wire

// ===== hdl/hciatt_front.sv =====
// Front end: byte-stream packet parser that turns finished ACL packets into reply jobs.
`default_nettype none
module hciatt_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [11:0]          csr_conn_handle_cfg,
   input  wire logic                 req_push,
   input  wire logic [7:0]           req_rx_byte,
   input  wire logic                 q_full,
   output logic                      req_full,
   output logic                      job_push,
   output hciatt_pkg::job_type       job_data
);
   import hciatt_pkg::*;

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_EV_OPCODE = 4'd1;
   localparam logic [3:0] PH_EV_LEN    = 4'd2;
   localparam logic [3:0] PH_EV_SKIP   = 4'd3;
   localparam logic [3:0] PH_ACL_H1    = 4'd4;
   localparam logic [3:0] PH_ACL_H2    = 4'd5;
   localparam logic [3:0] PH_ACL_D1    = 4'd6;
   localparam logic [3:0] PH_ACL_D2    = 4'd7;
   localparam logic [3:0] PH_ACL_DATA  = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] handle_ff, handle_in;
   logic [3:0]  pidx_ff, pidx_in;
   logic [7:0]  hs_ff [8];
   logic [7:0]  hs_in [8];
   logic [11:0] cfg_ff, cfg_in;
   logic        accept;
   logic        finish;
   logic        match;
   logic        is_err;
   logic        is_ntf;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign cfg_in   = csr_write_en ? csr_conn_handle_cfg : cfg_ff;

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      handle_in = handle_ff;
      pidx_in   = pidx_ff;
      finish    = 1'b0;
      for (int i = 0; i < 8; i++) begin
         hs_in[i] = hs_ff[i];
      end
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_rx_byte == HCI_TYPE_EVT) begin
                  phase_in = PH_EV_OPCODE;
               end else if (req_rx_byte == HCI_TYPE_ACL) begin
                  for (int i = 0; i < 8; i++) begin
                     hs_in[i] = 8'h00;
                  end
                  pidx_in   = 4'd0;
                  handle_in = 16'h0000;
                  left_in   = 16'h0000;
                  phase_in  = PH_ACL_H1;
               end
            end
            PH_EV_OPCODE: begin
               phase_in = PH_EV_LEN;
            end
            PH_EV_LEN: begin
               left_in  = {8'h00, req_rx_byte};
               phase_in = (req_rx_byte == 8'h00) ? PH_IDLE : PH_EV_SKIP;
            end
            PH_EV_SKIP: begin
               left_in = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_ACL_H1: begin
               handle_in = {8'h00, req_rx_byte};
               phase_in  = PH_ACL_H2;
            end
            PH_ACL_H2: begin
               handle_in = {req_rx_byte, handle_ff[7:0]};
               phase_in  = PH_ACL_D1;
            end
            PH_ACL_D1: begin
               left_in  = {8'h00, req_rx_byte};
               phase_in = PH_ACL_D2;
            end
            PH_ACL_D2: begin
               left_in  = {req_rx_byte, left_ff[7:0]};
               phase_in = ({req_rx_byte, left_ff[7:0]} == 16'h0000) ? PH_IDLE : PH_ACL_DATA;
            end
            PH_ACL_DATA: begin
               if (pidx_ff < HDR_BYTES) begin
                  hs_in[pidx_ff[2:0]] = req_rx_byte;
                  pidx_in = pidx_ff + 4'd1;
               end
               left_in = left_ff - 16'd1;
               if (left_ff == 16'd1) begin
                  phase_in = PH_IDLE;
                  finish   = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   assign match  = (handle_ff[11:0] == cfg_ff) && ({hs_in[3], hs_in[2]} == L2CAP_ATT_CID);
   assign is_err = (hs_in[4] == ATT_OP_FIND);
   assign is_ntf = (hs_in[4] == ATT_OP_NOTIFY) && ({hs_in[1], hs_in[0]} == L2CAP_NTF_LEN)
                   && (hs_in[5] == ATT_OP_NOTIFY) && (hs_in[6] == 8'h00);

   assign job_push        = finish && match && (is_err || is_ntf);
   assign job_data.notify = !is_err;
   assign job_data.handle = handle_ff[11:0];
   assign job_data.b0     = is_err ? hs_in[5] : hs_in[7];
   assign job_data.b1     = hs_in[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pidx_ff  <= 4'd0;
         cfg_ff   <= 12'h000;
      end else begin
         phase_ff <= phase_in;
         pidx_ff  <= pidx_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      handle_ff <= handle_in;
      for (int i = 0; i < 8; i++) begin
         hs_ff[i] <= hs_in[i];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/hciatt_job_q.sv =====
// Job queue: short register queue between the parser and the reply sequencer.
`default_nettype none
module hciatt_job_q (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire hciatt_pkg::job_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output hciatt_pkg::job_type       head_data
);
   import hciatt_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job queue push while full");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(DEPTH))
      else $error("job queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == CW'(DEPTH)) |-> (wr_ff == rd_ff))
      else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== hdl/hciatt_back.sv =====
// Back end: reply sequencer that expands jobs into result bytes behind an output register.
`default_nettype none
module hciatt_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire hciatt_pkg::job_type  q_data,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic                      rsp_out_kind,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_out_last
);
   import hciatt_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic       kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       load;
   logic       job_last;
   logic [7:0] err_byte;

   assign advance  = !vld_ff || rsp_pop;
   assign load     = advance && q_valid;
   assign job_last = q_data.notify || (idx_ff == ERR_LAST_IDX);
   assign q_pop    = load && job_last;

   always_comb begin
      case (idx_ff)
         4'd0:    err_byte = HCI_TYPE_ACL;
         4'd1:    err_byte = q_data.handle[7:0];
         4'd2:    err_byte = {4'h2, q_data.handle[11:8]};
         4'd3:    err_byte = 8'h09;
         4'd4:    err_byte = 8'h00;
         4'd5:    err_byte = 8'h05;
         4'd6:    err_byte = 8'h00;
         4'd7:    err_byte = L2CAP_ATT_CID[7:0];
         4'd8:    err_byte = L2CAP_ATT_CID[15:8];
         4'd9:    err_byte = ATT_OP_ERROR;
         4'd10:   err_byte = ATT_OP_FIND;
         4'd11:   err_byte = q_data.b0;
         4'd12:   err_byte = q_data.b1;
         4'd13:   err_byte = 8'h0A;
         default: err_byte = 8'h00;
      endcase
   end

   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      kind_in = kind_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      if (load) begin
         vld_in  = 1'b1;
         kind_in = q_data.notify;
         byte_in = q_data.notify ? q_data.b0 : err_byte;
         last_in = job_last;
         idx_in  = job_last ? 4'd0 : idx_ff + 4'd1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_empty    = !vld_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset) load |=> vld_ff)
      else $error("loaded reply byte not presented");
   a_mid_job: assert property (@(posedge clock) disable iff (reset) (idx_ff != 4'd0) |-> q_valid)
      else $error("reply index advanced without a job");
   a_idx_range: assert property (@(posedge clock) disable iff (reset) idx_ff <= ERR_LAST_IDX)
      else $error("reply index out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !rsp_pop) |=> (vld_ff && $stable(byte_ff) && $stable(last_ff)))
      else $error("unaccepted reply byte changed");

endmodule
`default_nettype wire

// ===== hdl/hci_acl_att_error_responder.sv =====
// Top level: HCI byte parser answering ATT requests on the configured connection.
// Path: once a packet's last byte is accepted, its job is written into a queue slot and the first
// reply byte is then loaded into the output register, when the sequencer is idle.
// Throughput: one received byte per cycle; input stalls only while both job slots are taken.
// Replies drain one byte per cycle while popped (14 for an error reply, 1 for a notification).
// Reset (synchronous, active high): parser idle, handle register zero, queue and output empty.
`default_nettype none
module hci_acl_att_error_responder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic [11:0] csr_conn_handle_cfg,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last
);
   import hciatt_pkg::*;

   logic    job_push;
   job_type job_data;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   job_type q_data;

   hciatt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_conn_handle_cfg (csr_conn_handle_cfg),
      .req_push            (req_push),
      .req_rx_byte         (req_rx_byte),
      .q_full              (q_full),
      .req_full            (req_full),
      .job_push            (job_push),
      .job_data            (job_data)
   );

   hciatt_job_q u_job_q (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   hciatt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
`default_nettype wire
